// ===== sv/ptob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptob_pkg: shared definitions for the pixel tile orientation buffer
// Field widths, register indexes, item kinds and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptob_pkg;

    // Fixed field widths.
    localparam int POS_W      = 6;
    localparam int SIDE_W     = 7;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 4 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Default for the largest tile side that the store holds.
    localparam int DEFAULT_MAX_SIDE = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_VERT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_HORIZ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 3'd4;

    // Reset values of the tile size registers.
    localparam logic [SIDE_W-1:0] TILE_SIDE_RESET = 7'd64;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mem_write;  // store the incoming pixel
        logic mem_read;   // look up the oriented pixel and latch the request
        logic out_load;   // move the fetched pixel into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;    // the offered beat is a read
        logic in_tile;    // the offered position lies inside the tile
    } t_stat;

endpackage

// ===== sv/ptob_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptob_ctrl: controller of the pixel tile orientation buffer
// Two-state machine that issues stores and lookups, waits in a fetch state for
// the pixel memory, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ptob_ctrl
    import ptob_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   out_free;

    // New beats are taken only while no lookup is in flight.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Command decode.
    always_comb begin
        o_cmd.mem_write = in_fire && !i_stat.is_read && i_stat.in_tile;
        o_cmd.mem_read  = in_fire && i_stat.is_read;
        o_cmd.out_load  = (r_state == ST_FETCH) && out_free;
    end

    // Next state and output valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.mem_read) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (o_cmd.out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    // A lookup always moves the machine into the fetch state.
    a_read_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_read |=> (r_state == ST_FETCH))
        else $error("lookup did not enter fetch state");

    // The memory port is never asked to store and look up together.
    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mem_write && o_cmd.mem_read))
        else $error("store and lookup issued together");

    // A fetched pixel never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");

    // Every output load presents a result in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("output load did not present a result");
`endif

endmodule

// ===== sv/ptob_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptob_dpath: datapath of the pixel tile orientation buffer
// Configuration registers, the orientation remap of the read position, the
// pixel memory and the registered result payload.
// ----------------------------------------------------------------------------
module ptob_dpath
    import ptob_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_kind,
    input  logic [POS_W-1:0]      i_pos_row,
    input  logic [POS_W-1:0]      i_pos_col,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    input  logic [CHAN_W-1:0]     i_in_alpha,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [POS_W-1:0]      o_out_row,
    output logic [POS_W-1:0]      o_out_col,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic [CHAN_W-1:0]     o_out_alpha,
    output logic                  o_out_of_range
);

    localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CAP_I     = (MAX_SIDE > (2 ** SIDE_W) - 1) ? (2 ** SIDE_W) - 1 : MAX_SIDE;
    localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(CAP_I);
    localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(MAX_SIDE);

    // Configuration registers.
    logic [SIDE_W-1:0] r_tile_width;
    logic [SIDE_W-1:0] r_tile_height;
    logic              r_mirror_vert;
    logic              r_mirror_horiz;
    logic [1:0]        r_quarter_turns;

    // Remap signals.
    logic [SIDE_W-1:0] eff_w, eff_h;
    logic [SIDE_W-1:0] row_x, col_x;
    logic [SIDE_W-1:0] turn_r, turn_c;
    logic [SIDE_W-1:0] map_r, map_c;
    logic              in_tile;
    logic [ADDR_W-1:0] mem_addr;

    // Memory and result registers.
    logic [PIXEL_W-1:0] r_pixel_mem [MEM_DEPTH];
    logic [PIXEL_W-1:0] r_rd_data;
    logic [POS_W-1:0]   r_req_row, r_req_col;
    logic               r_req_oor;
    logic [POS_W-1:0]   r_out_row, r_out_col;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               r_out_oor;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width    <= TILE_SIDE_RESET;
            r_tile_height   <= TILE_SIDE_RESET;
            r_mirror_vert   <= 1'b0;
            r_mirror_horiz  <= 1'b0;
            r_quarter_turns <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TILE_WIDTH:    r_tile_width    <= i_cfg_data[SIDE_W-1:0];
                CFG_TILE_HEIGHT:   r_tile_height   <= i_cfg_data[SIDE_W-1:0];
                CFG_MIRROR_VERT:   r_mirror_vert   <= i_cfg_data[0];
                CFG_MIRROR_HORIZ:  r_mirror_horiz  <= i_cfg_data[0];
                CFG_QUARTER_TURNS: r_quarter_turns <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective tile size, saturated to the store side.
    assign eff_w   = (r_tile_width  > SIDE_CAP) ? SIDE_CAP : r_tile_width;
    assign eff_h   = (r_tile_height > SIDE_CAP) ? SIDE_CAP : r_tile_height;
    assign row_x   = {1'b0, i_pos_row};
    assign col_x   = {1'b0, i_pos_col};
    assign in_tile = (row_x < eff_h) && (col_x < eff_w);

    // Undo the clockwise turns (square tiles only), then the mirrors.
    always_comb begin
        turn_r = row_x;
        turn_c = col_x;
        if (eff_w == eff_h) begin
            case (r_quarter_turns)
                2'd1: begin
                    turn_r = eff_w - 7'd1 - col_x;
                    turn_c = row_x;
                end
                2'd2: begin
                    turn_r = eff_w - 7'd1 - row_x;
                    turn_c = eff_w - 7'd1 - col_x;
                end
                2'd3: begin
                    turn_r = col_x;
                    turn_c = eff_w - 7'd1 - row_x;
                end
                default: begin
                    turn_r = row_x;
                    turn_c = col_x;
                end
            endcase
        end
        map_c = r_mirror_horiz ? (eff_w - 7'd1 - turn_c) : turn_c;
        map_r = r_mirror_vert  ? (eff_h - 7'd1 - turn_r) : turn_r;
    end

    // Loads address the stored position directly, reads the remapped one.
    always_comb begin
        if (i_kind == KIND_READ) begin
            mem_addr = ADDR_W'(map_r) * SIDE_A + ADDR_W'(map_c);
        end else begin
            mem_addr = ADDR_W'(row_x) * SIDE_A + ADDR_W'(col_x);
        end
    end

    always_comb begin
        o_stat.is_read = (i_kind == KIND_READ);
        o_stat.in_tile = in_tile;
    end

    // Pixel memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_pixel_mem[mem_addr] <= {i_in_red, i_in_green, i_in_blue, i_in_alpha};
        end
        if (i_cmd.mem_read && in_tile) begin
            r_rd_data <= r_pixel_mem[mem_addr];
        end
    end

    // Request echo, held while the lookup completes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_req_row <= i_pos_row;
            r_req_col <= i_pos_col;
            r_req_oor <= !in_tile;
        end
    end

    // Output payload; channels read as zero outside the tile.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row   <= r_req_row;
            r_out_col   <= r_req_col;
            r_out_oor   <= r_req_oor;
            r_out_pixel <= r_req_oor ? '0 : r_rd_data;
        end
    end

    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_out_red      = r_out_pixel[4*CHAN_W-1:3*CHAN_W];
    assign o_out_green    = r_out_pixel[3*CHAN_W-1:2*CHAN_W];
    assign o_out_blue     = r_out_pixel[2*CHAN_W-1:CHAN_W];
    assign o_out_alpha    = r_out_pixel[CHAN_W-1:0];
    assign o_out_of_range = r_out_oor;

endmodule

// ===== sv/pixel_tile_orientation_buffer_core.sv =====
`timescale 1ns / 1ps
// Usage:
// The input channel (i_in_valid / o_in_ready) carries load and read beats.
// A load beat writes one RGBA pixel at its row and column of the stored tile
// and gives no result; a load outside the tile is dropped. A read beat gives
// one result beat on the output channel (o_out_valid / i_out_ready): the
// pixel seen at the requested position after the vertical mirror, horizontal
// mirror and clockwise quarter turns (turns only on square tiles).
// Reads outside the tile return zero channels with o_out_of_range set.
// Throughput: one load per cycle while no read is in flight; a read holds off
// new beats through its lookup in the registered read port of the pixel memory
// and its output load, after which the result is valid in the output register.
// The output register lets the next beat enter while a result waits; a read
// that finds the output still stalled holds in its fetch state until the
// receiver takes the waiting result.
// Reset clears the configuration to a 64 by 64 tile with no mirror or turn
// and empties the output; pixel memory contents stay undefined until loaded.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// pixel_tile_orientation_buffer_core: re-orientable RGBA tile buffer
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module pixel_tile_orientation_buffer_core
    import ptob_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [POS_W-1:0]      i_pos_row,
    input  logic [POS_W-1:0]      i_pos_col,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    input  logic [CHAN_W-1:0]     i_in_alpha,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [POS_W-1:0]      o_out_row,
    output logic [POS_W-1:0]      o_out_col,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic [CHAN_W-1:0]     o_out_alpha,
    output logic                  o_out_of_range
);

    t_cmd  cmd;
    t_stat stat;

    // Controller.
    ptob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath.
    ptob_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_pos_row      (i_pos_row),
        .i_pos_col      (i_pos_col),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_in_alpha     (i_in_alpha),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .o_out_of_range (o_out_of_range)
    );

endmodule
